/* hdl/bcpe_pkg.sv */
// ---------------------------------------------------------------------------
// Bezier point evaluator package
// Shared coordinate types, fixed-point constants and command codes.
// ---------------------------------------------------------------------------
`default_nettype none

package bcpe_pkg;

  localparam int COORD_BITS     = 16;
  localparam int FRAC_BITS      = 16;
  localparam int T_BITS         = FRAC_BITS + 1;
  localparam int DEG_BITS       = 3;
  localparam int MAX_DEGREE_DEF = 7;

  localparam logic [T_BITS-1:0]   T_ONE     = T_BITS'(1) << FRAC_BITS;
  localparam logic [DEG_BITS-1:0] DEG_RESET = DEG_BITS'(3);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef coord_t [2:0] point_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_t;

endpackage

`default_nettype wire

/* hdl/bcpe_ram.sv */
// ---------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module bcpe_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/bcpe_lerp_unit.sv */
// ---------------------------------------------------------------------------
// Shared interpolation unit
// Three coordinate lanes computing a + floor(((b - a) * t + half) / one),
// with the product registered before the rounding add.
// ---------------------------------------------------------------------------
`default_nettype none

module bcpe_lerp_unit (
  input  wire logic                          clk,
  input  wire logic                          cap,
  input  wire bcpe_pkg::point_t              a_pt,
  input  wire bcpe_pkg::point_t              b_pt,
  input  wire logic [bcpe_pkg::T_BITS-1:0]   t_val,
  output bcpe_pkg::point_t                   res_pt
);

  import bcpe_pkg::*;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = DIFF_W + T_BITS + 1;
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (FRAC_BITS - 1);

  logic signed [PROD_W-1:0] prod_r   [3];
  logic signed [PROD_W-1:0] prod_nxt [3];
  point_t                   a_r;
  logic signed [DIFF_W-1:0] diff     [3];
  logic signed [T_BITS:0]   t_s;
  logic signed [PROD_W-1:0] rnd      [3];
  logic signed [PROD_W-1:0] quo      [3];

  always_comb begin
    t_s = $signed({1'b0, t_val});
    for (int c = 0; c < 3; c++) begin
      diff[c]     = DIFF_W'(b_pt[c]) - DIFF_W'(a_pt[c]);
      prod_nxt[c] = diff[c] * t_s;
      rnd[c]      = prod_r[c] + HALF;
      quo[c]      = rnd[c] >>> FRAC_BITS;
      res_pt[c]   = a_r[c] + coord_t'(quo[c][COORD_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cap) begin
      a_r <= a_pt;
      for (int c = 0; c < 3; c++) begin
        prod_r[c] <= prod_nxt[c];
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/bezier_curve_point_eval.sv */
// ---------------------------------------------------------------------------
// Bezier curve point evaluator
// Evaluates a three-dimensional Bezier curve by de Casteljau interpolation.
//
// A request on the in_ channel either loads one control point (in_command
// low) or evaluates the curve at in_param_t (in_command high, Q1.16, values
// above one are taken as one). A load gives no result; loads are accepted
// even while a finished point still waits on the out_ channel. An
// evaluation copies points 0..n from the point memory into a shift line and
// then runs n rounds of interpolation through one shared three-lane
// multiply unit, each interpolation in a multiply step and an add step and
// each round closed by a retire step. in_ready is low from the taken
// request until the result moves into the output register. The degree comes
// from cfg_wdata, written when cfg_we is high, and is limited to MAX_DEGREE.
// Reset sets the degree to three and empties the out_ channel; the point
// memory is not cleared. If the receiver stalls, the finished point waits
// in the sequencer until the output register is freed, and no new request
// is taken meanwhile.
// ---------------------------------------------------------------------------
`default_nettype none

module bezier_curve_point_eval #(
  parameter int MAX_DEGREE = bcpe_pkg::MAX_DEGREE_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [bcpe_pkg::DEG_BITS-1:0]   cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_command,
  input  wire logic [2:0]                      in_point_index,
  input  wire bcpe_pkg::coord_t                in_x,
  input  wire bcpe_pkg::coord_t                in_y,
  input  wire bcpe_pkg::coord_t                in_z,
  input  wire logic [bcpe_pkg::T_BITS-1:0]     in_param_t,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output bcpe_pkg::coord_t                     out_x,
  output bcpe_pkg::coord_t                     out_y,
  output bcpe_pkg::coord_t                     out_z
);

  import bcpe_pkg::*;

  localparam int NPTS = MAX_DEGREE + 1;
  localparam int AW   = $clog2(NPTS);
  localparam logic [AW-1:0] MAX_N = AW'(MAX_DEGREE);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_FILL,
    S_MUL,
    S_ADD,
    S_DROP,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [DEG_BITS-1:0] cfg_deg_r, cfg_deg_nxt;
  logic [T_BITS-1:0]   t_r, t_nxt;
  logic [AW-1:0]       n_r, n_nxt;
  logic [AW-1:0]       rd_addr_r, rd_addr_nxt;
  logic                fill_vld_r, fill_vld_nxt;
  logic [AW-1:0]       fill_pos_r, fill_pos_nxt;
  logic [AW-1:0]       r_r, r_nxt;
  logic [AW-1:0]       i_r, i_nxt;
  logic                out_valid_r, out_valid_nxt;
  point_t              out_pt_r, out_pt_nxt;
  point_t              w_r   [NPTS];
  point_t              w_nxt [NPTS];

  logic        in_acc;
  logic        idx_ok;
  logic        ram_we;
  point_t      ld_pt;
  point_t      ram_rdata;
  point_t      lerp_res;
  logic [AW-1:0] deg_sat;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign idx_ok    = (32'(in_point_index) <= MAX_DEGREE);
  assign ram_we    = in_acc && (in_command == CMD_LOAD) && idx_ok;
  assign out_valid = out_valid_r;
  assign out_x     = out_pt_r[0];
  assign out_y     = out_pt_r[1];
  assign out_z     = out_pt_r[2];

  always_comb begin
    ld_pt[0] = in_x;
    ld_pt[1] = in_y;
    ld_pt[2] = in_z;
  end

  always_comb begin
    if (32'(cfg_deg_r) > MAX_DEGREE) begin
      deg_sat = MAX_N;
    end else begin
      deg_sat = AW'(cfg_deg_r);
    end
  end

  bcpe_ram #(
    .WIDTH ($bits(point_t)),
    .DEPTH (NPTS)
  ) u_points (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_point_index)),
    .wdata (ld_pt),
    .re    (state_r == S_READ),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  bcpe_lerp_unit u_lerp (
    .clk    (clk),
    .cap    (state_r == S_MUL),
    .a_pt   (w_r[0]),
    .b_pt   (w_r[1]),
    .t_val  (t_r),
    .res_pt (lerp_res)
  );

  always_comb begin
    state_nxt     = state_r;
    cfg_deg_nxt   = cfg_deg_r;
    t_nxt         = t_r;
    n_nxt         = n_r;
    rd_addr_nxt   = rd_addr_r;
    fill_vld_nxt  = 1'b0;
    fill_pos_nxt  = rd_addr_r;
    r_nxt         = r_r;
    i_nxt         = i_r;
    out_valid_nxt = out_valid_r;
    out_pt_nxt    = out_pt_r;

    if (cfg_we) begin
      cfg_deg_nxt = cfg_wdata;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_command == CMD_EVAL)) begin
          t_nxt       = (in_param_t > T_ONE) ? T_ONE : in_param_t;
          n_nxt       = deg_sat;
          rd_addr_nxt = '0;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        fill_vld_nxt = 1'b1;
        if (rd_addr_r == n_r) begin
          state_nxt = S_FILL;
        end else begin
          rd_addr_nxt = rd_addr_r + 1'b1;
        end
      end
      S_FILL: begin
        r_nxt = n_r;
        i_nxt = '0;
        if (n_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_ADD;
      end
      S_ADD: begin
        i_nxt = i_r + 1'b1;
        if (i_r == AW'(r_r - 1'b1)) begin
          state_nxt = S_DROP;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_DROP: begin
        r_nxt = r_r - 1'b1;
        i_nxt = '0;
        if (r_r == AW'(1)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_pt_nxt    = w_r[0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_deg_r   <= DEG_RESET;
      fill_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_deg_r   <= cfg_deg_nxt;
      fill_vld_r  <= fill_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    t_r        <= t_nxt;
    n_r        <= n_nxt;
    rd_addr_r  <= rd_addr_nxt;
    fill_pos_r <= fill_pos_nxt;
    r_r        <= r_nxt;
    i_r        <= i_nxt;
    out_pt_r   <= out_pt_nxt;
  end

  // The work line is a queue: each interpolation pops the head and appends
  // its result behind the live entries; the retire step pops the last one.
  always_comb begin
    for (int k = 0; k < NPTS; k++) begin
      w_nxt[k] = w_r[k];
    end
    if (fill_vld_r) begin
      for (int k = 0; k < NPTS; k++) begin
        if (AW'(k) == fill_pos_r) begin
          w_nxt[k] = ram_rdata;
        end
      end
    end
    if ((state_r == S_ADD) || (state_r == S_DROP)) begin
      for (int k = 0; k < NPTS - 1; k++) begin
        w_nxt[k] = w_r[k + 1];
      end
    end
    if (state_r == S_ADD) begin
      for (int k = 0; k < NPTS; k++) begin
        if (AW'(k) == r_r) begin
          w_nxt[k] = lerp_res;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NPTS; k++) begin
      w_r[k] <= w_nxt[k];
    end
  end

  a_step_in_round: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD) |-> (i_r < r_r))
    else $error("interpolation step beyond the live entries of the round");

  a_round_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_MUL) || (state_r == S_DROP)) |-> ((r_r != '0) && (r_r <= n_r)))
    else $error("round counter outside the curve degree");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result presented without a finished evaluation");

  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE))
    else $error("control point written during an evaluation");

endmodule

`default_nettype wire

/* verif/bezier_point_checker.sv */
// ---------------------------------------------------------------------------
// Bezier point checker
// Watches the configuration port and the in_ and out_ channels of the Bezier
// curve point evaluator. It mirrors the control points and the curve degree,
// predicts each evaluated point by de Casteljau interpolation and compares
// every returned point with the oldest prediction still outstanding.
// ---------------------------------------------------------------------------
module bezier_point_checker
  import bcpe_pkg::*;
#(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [DEG_BITS-1:0] cfg_wdata,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                in_command,
  input  logic [2:0]          in_point_index,
  input  coord_t              in_x,
  input  coord_t              in_y,
  input  coord_t              in_z,
  input  logic [T_BITS-1:0]   in_param_t,
  input  logic                out_valid,
  input  logic                out_ready,
  input  coord_t              out_x,
  input  coord_t              out_y,
  input  coord_t              out_z,
  output int                  fail_count,
  output int                  pending
);

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
  } curve_point_t;

  coord_t              pts_x [0:7];
  coord_t              pts_y [0:7];
  coord_t              pts_z [0:7];
  logic [DEG_BITS-1:0] degree;
  curve_point_t        expected_points [$];

  function automatic curve_point_t eval_curve(input logic [DEG_BITS-1:0] deg,
                                              input logic [T_BITS-1:0] t_raw);
    longint       work [0:7];
    longint       t;
    int           n;
    curve_point_t res;
    t = (t_raw > T_ONE) ? longint'(T_ONE) : longint'(t_raw);
    n = int'(deg);
    if (n > MAX_DEGREE) n = MAX_DEGREE;
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i <= n; i++) begin
        work[i] = longint'((c == 0) ? pts_x[i] : (c == 1) ? pts_y[i] : pts_z[i]);
      end
      for (int r = n; r > 0; r--) begin
        for (int i = 0; i < r; i++) begin
          work[i] = work[i] + (((work[i+1] - work[i]) * t + 32768) >>> 16);
        end
      end
      case (c)
        0: res.x = coord_t'(work[0]);
        1: res.y = coord_t'(work[0]);
        default: res.z = coord_t'(work[0]);
      endcase
    end
    return res;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
    degree     = DEG_RESET;
  end

  always @(posedge clk) begin
    curve_point_t exp_pt;
    if (!rst_n) begin
      degree = DEG_RESET;
      expected_points.delete();
      pending = 0;
    end else begin
      if (in_valid && in_ready) begin
        if (in_command == CMD_EVAL) begin
          expected_points.push_back(eval_curve(degree, in_param_t));
        end else if (32'(in_point_index) <= MAX_DEGREE) begin
          pts_x[in_point_index] = in_x;
          pts_y[in_point_index] = in_y;
          pts_z[in_point_index] = in_z;
        end
      end
      if (cfg_we) degree = cfg_wdata;
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          $error("Unexpected result request: x %0d, y %0d, z %0d", out_x, out_y, out_z);
          fail_count++;
        end else begin
          exp_pt = expected_points.pop_front();
          if (out_x !== exp_pt.x) begin
            $error("out_x mismatch: expected %0d, actual %0d", exp_pt.x, out_x);
            fail_count++;
          end
          if (out_y !== exp_pt.y) begin
            $error("out_y mismatch: expected %0d, actual %0d", exp_pt.y, out_y);
            fail_count++;
          end
          if (out_z !== exp_pt.z) begin
            $error("out_z mismatch: expected %0d, actual %0d", exp_pt.z, out_z);
            fail_count++;
          end
        end
      end
      pending = expected_points.size();
    end
  end

endmodule

/* verif/bezier_curve_point_eval_tb.sv */
// ---------------------------------------------------------------------------
// Bezier curve point evaluator testbench
// Loads control points and evaluates curves across several degree settings,
// first with directed extremes and then with random requests, while both
// channels idle and stall at random. A separate checker predicts every
// evaluated point and counts mismatches.
// ---------------------------------------------------------------------------
module bezier_curve_point_eval_tb;
  import bcpe_pkg::*;

  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 400;

  localparam coord_t C_HI   = coord_t'(32767);
  localparam coord_t C_LO   = coord_t'(-32768);
  localparam coord_t C_ZERO = coord_t'(0);
  localparam coord_t C_NEG1 = coord_t'(-1);

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [DEG_BITS-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic                in_command;
  logic [2:0]          in_point_index;
  coord_t              in_x;
  coord_t              in_y;
  coord_t              in_z;
  logic [T_BITS-1:0]   in_param_t;
  logic                out_valid;
  logic                out_ready;
  coord_t              out_x;
  coord_t              out_y;
  coord_t              out_z;
  int                  fail_count;
  int                  pending;
  bit                  no_idle;
  bit                  rx_hold;

  always #5 clk = ~clk;

  bezier_curve_point_eval dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_point_index (in_point_index),
    .in_x           (in_x),
    .in_y           (in_y),
    .in_z           (in_z),
    .in_param_t     (in_param_t),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_z          (out_z)
  );

  bezier_point_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_point_index (in_point_index),
    .in_x           (in_x),
    .in_y           (in_y),
    .in_z           (in_z),
    .in_param_t     (in_param_t),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_z          (out_z),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0: return coord_t'(32767);
      1: return coord_t'(-32768);
      2: return coord_t'(0);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [T_BITS-1:0] rand_param();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return T_ONE;
      2: return T_BITS'($urandom_range(65537, 131071));
      default: return T_BITS'($urandom_range(0, 65536));
    endcase
  endfunction

  // Each call starts and ends at a falling edge; valid is lowered only for a gap.
  task automatic send_req(input cmd_t cmd, input logic [2:0] idx, input coord_t x,
                          input coord_t y, input coord_t z, input logic [T_BITS-1:0] t);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_point_index <= idx;
    in_x           <= x;
    in_y           <= y;
    in_z           <= z;
    in_param_t     <= t;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_degree(input logic [DEG_BITS-1:0] deg);
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= deg;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall > 0 || rx_hold) out_ready <= 1'b0;
      repeat (stall) @(negedge clk);
      if (rx_hold) begin
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold = 1'b0;
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    cmd_t cmd;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_command     = CMD_LOAD;
    in_point_index = '0;
    in_x           = '0;
    in_y           = '0;
    in_z           = '0;
    in_param_t     = '0;
    no_idle        = 1'b0;
    rx_hold        = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Every control point is loaded before the first evaluation request.
    send_req(CMD_LOAD, 3'd0, C_HI, C_LO, C_ZERO, rand_param());
    send_req(CMD_LOAD, 3'd1, C_LO, C_HI, C_NEG1, rand_param());
    send_req(CMD_LOAD, 3'd2, C_ZERO, C_NEG1, C_HI, rand_param());
    send_req(CMD_LOAD, 3'd3, C_NEG1, C_ZERO, C_LO, rand_param());
    send_req(CMD_LOAD, 3'd4, C_HI, C_HI, C_LO, rand_param());
    send_req(CMD_LOAD, 3'd5, C_LO, C_LO, C_HI, rand_param());
    send_req(CMD_LOAD, 3'd6, C_HI, C_LO, C_HI, rand_param());
    send_req(CMD_LOAD, 3'd7, C_LO, C_HI, C_LO, rand_param());
    send_req(CMD_EVAL, 3'($urandom), rand_coord(), rand_coord(), rand_coord(), '0);
    send_req(CMD_EVAL, 3'($urandom), rand_coord(), rand_coord(), rand_coord(), T_ONE);
    send_req(CMD_EVAL, 3'($urandom), rand_coord(), rand_coord(), rand_coord(), 17'd32768);
    send_req(CMD_EVAL, 3'($urandom), rand_coord(), rand_coord(), rand_coord(), 17'd1);
    send_req(CMD_EVAL, 3'($urandom), rand_coord(), rand_coord(), rand_coord(), 17'd65535);
    send_req(CMD_EVAL, 3'($urandom), rand_coord(), rand_coord(), rand_coord(), 17'd65537);
    send_req(CMD_EVAL, 3'($urandom), rand_coord(), rand_coord(), rand_coord(), 17'd131071);
    write_degree(3'd0);
    send_req(CMD_EVAL, 3'($urandom), rand_coord(), rand_coord(), rand_coord(), 17'd12345);
    send_req(CMD_EVAL, 3'($urandom), rand_coord(), rand_coord(), rand_coord(), T_ONE);
    write_degree(3'd7);
    send_req(CMD_EVAL, 3'($urandom), rand_coord(), rand_coord(), rand_coord(), '0);
    send_req(CMD_EVAL, 3'($urandom), rand_coord(), rand_coord(), rand_coord(), T_ONE);
    send_req(CMD_EVAL, 3'($urandom), rand_coord(), rand_coord(), rand_coord(), 17'd131071);
    send_req(CMD_EVAL, 3'($urandom), rand_coord(), rand_coord(), rand_coord(), 17'd32768);

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: write_degree(3'd1);
        1: write_degree(3'd7);
        2: write_degree(3'd0);
        default: write_degree(3'($urandom_range(0, 7)));
      endcase
      no_idle = (ph % 3 == 2);
      if (ph == 4) rx_hold = 1'b1;
      for (int k = 0; k < 100; k++) begin
        if (ph == 5 && k == 50) wait_idle();
        cmd = ($urandom_range(0, 9) < 4) ? CMD_LOAD : CMD_EVAL;
        send_req(cmd, 3'($urandom), rand_coord(), rand_coord(), rand_coord(), rand_param());
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
